/* rtl/abas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC block average scaler package
// Payload types carried on the channel interface, and register indexes, field
// widths and reset values used by the block.
// ----------------------------------------------------------------------------
package abas_pkg;

  localparam int unsigned SampleW  = 12;
  localparam int unsigned GainW    = 18;
  localparam int unsigned GainFrac = 16;
  localparam int unsigned CurScW   = 16;
  localparam int unsigned VoltScW  = 15;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 18;

  localparam int unsigned SamplesPerBlockDef = 16;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegCurrentZero   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCurrentGain   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegVoltageOffset = 2'd2;
  localparam logic [CfgIdxW-1:0] RegVoltageGain   = 2'd3;

  localparam logic [SampleW-1:0] CurrentZeroRst   = 12'd7;
  localparam logic [GainW-1:0]   CurrentGainRst   = 18'd78019;  // 10 / 8.4 in Q2.16
  localparam logic [SampleW-1:0] VoltageOffsetRst = 12'd17;
  localparam logic [GainW-1:0]   VoltageGainRst   = 18'd12676;  // 1 / 5.17 in Q2.16

  typedef struct packed {
    logic [SampleW-1:0] current1_sample;
    logic [SampleW-1:0] current2_sample;
    logic [SampleW-1:0] voltage_sample;
  } sample_t;

  typedef struct packed {
    logic [SampleW-1:0] current1_mean;
    logic [SampleW-1:0] current2_mean;
    logic [SampleW-1:0] voltage_mean;
    logic [CurScW-1:0]  current1_scaled;
    logic [CurScW-1:0]  current2_scaled;
    logic [VoltScW-1:0] voltage_scaled;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

/* rtl/abas_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC block average scaler channel
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface abas_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/adc_block_average_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC block average scaler
// Block means of two current channels and one voltage channel, with offset
// correction and Q2.16 gain scaling.
// ----------------------------------------------------------------------------
// One sample triple is taken every cycle unless the input stalls. Each block
// of SAMPLES_PER_BLOCK samples yields one result beat: one register holds the
// block sums, one the means (a multiply by the reciprocal of the block
// length), one the scaled result. The input stalls only on a block's last
// sample while all three of these registers are occupied and the output is
// held. Configuration is taken at any cycle and should be written only while
// the block is idle. Once either current mean falls below current_zero, the
// current offset stays at zero until reset.
module adc_block_average_scaler #(
  parameter int unsigned SAMPLES_PER_BLOCK = abas_pkg::SamplesPerBlockDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  abas_stream_if.sink   cfg_i,
  abas_stream_if.sink   in_i,
  abas_stream_if.source out_o
);

  localparam int unsigned SampleW = abas_pkg::SampleW;
  localparam int unsigned GainW   = abas_pkg::GainW;
  localparam int unsigned Frac    = abas_pkg::GainFrac;
  localparam int unsigned Log2N   = $clog2(SAMPLES_PER_BLOCK);
  localparam int unsigned CntW    = (SAMPLES_PER_BLOCK > 1) ? Log2N : 1;
  localparam int unsigned SumW    = SampleW + Log2N;
  // floor(x / N) == (x * Recip) >> RecipShift for every x below 2**SumW
  localparam int unsigned RecipShift = SumW + Log2N;
  localparam int unsigned RecipW     = SumW + 1;
  localparam longint unsigned Recip  =
    ((64'd1 << RecipShift) + 64'(SAMPLES_PER_BLOCK) - 64'd1) / 64'(SAMPLES_PER_BLOCK);
  localparam int unsigned ProdW      = SumW + RecipW;
  localparam int unsigned CurProdW   = SampleW + GainW;
  localparam int unsigned VDiffW     = SampleW + 2;
  localparam int unsigned VProdW     = VDiffW - 1 + GainW;

  localparam logic [CntW-1:0]   LastCnt  = CntW'(SAMPLES_PER_BLOCK - 1);
  localparam logic [RecipW-1:0] RecipVal = Recip[RecipW-1:0];

  // ---------------- configuration ----------------
  logic [SampleW-1:0] current_zero_q;
  logic [GainW-1:0]   current_gain_q;
  logic [SampleW-1:0] voltage_offset_q;
  logic [GainW-1:0]   voltage_gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_zero_q   <= abas_pkg::CurrentZeroRst;
      current_gain_q   <= abas_pkg::CurrentGainRst;
      voltage_offset_q <= abas_pkg::VoltageOffsetRst;
      voltage_gain_q   <= abas_pkg::VoltageGainRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        abas_pkg::RegCurrentZero:   current_zero_q   <= cfg_i.data.data[SampleW-1:0];
        abas_pkg::RegCurrentGain:   current_gain_q   <= cfg_i.data.data[GainW-1:0];
        abas_pkg::RegVoltageOffset: voltage_offset_q <= cfg_i.data.data[SampleW-1:0];
        abas_pkg::RegVoltageGain:   voltage_gain_q   <= cfg_i.data.data[GainW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage flow control ----------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_adv, s2_free, s1_free;
  logic is_last, in_fire;
  logic [CntW-1:0] cnt_q;

  assign out_adv = !out_valid_q || out_o.ready;
  assign s2_free = !s2_valid_q || out_adv;
  assign s1_free = !s1_valid_q || s2_free;

  assign is_last     = (cnt_q == LastCnt);
  assign in_i.ready  = s1_free || !is_last;
  assign in_fire     = in_i.valid && in_i.ready;

  // ---------------- accumulation ----------------
  logic [SumW-1:0] c1_sum_q, c2_sum_q, v_sum_q;
  logic [SumW-1:0] c1_sum_d, c2_sum_d, v_sum_d;
  logic [SumW-1:0] s1_c1_q, s1_c2_q, s1_v_q;

  assign c1_sum_d = c1_sum_q + SumW'(in_i.data.current1_sample);
  assign c2_sum_d = c2_sum_q + SumW'(in_i.data.current2_sample);
  assign v_sum_d  = v_sum_q  + SumW'(in_i.data.voltage_sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      c1_sum_q <= '0;
      c2_sum_q <= '0;
      v_sum_q  <= '0;
    end else if (in_fire) begin
      if (is_last) begin
        // restart the sums for the next block
        cnt_q    <= '0;
        c1_sum_q <= '0;
        c2_sum_q <= '0;
        v_sum_q  <= '0;
      end else begin
        cnt_q    <= cnt_q + CntW'(1);
        c1_sum_q <= c1_sum_d;
        c2_sum_q <= c2_sum_d;
        v_sum_q  <= v_sum_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_fire && is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_fire && is_last) begin
      s1_c1_q <= c1_sum_d;
      s1_c2_q <= c2_sum_d;
      s1_v_q  <= v_sum_d;
    end
  end

  // ---------------- means ----------------
  logic [ProdW-1:0]   c1_prod, c2_prod, v_prod;
  logic [SampleW-1:0] s2_m1_q, s2_m2_q, s2_mv_q;

  assign c1_prod = ProdW'(s1_c1_q) * ProdW'(RecipVal);
  assign c2_prod = ProdW'(s1_c2_q) * ProdW'(RecipVal);
  assign v_prod  = ProdW'(s1_v_q)  * ProdW'(RecipVal);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) begin
      s2_m1_q <= c1_prod[RecipShift +: SampleW];
      s2_m2_q <= c2_prod[RecipShift +: SampleW];
      s2_mv_q <= v_prod[RecipShift +: SampleW];
    end
  end

  // ---------------- offset and scaling ----------------
  logic                      offset_cleared_q, offset_cleared_d;
  logic [SampleW-1:0]        zero_eff, c1_diff, c2_diff;
  logic [CurProdW-1:0]       c1_scl, c2_scl;
  logic signed [VDiffW-1:0]  v_diff;
  logic [VProdW-1:0]         v_scl;
  logic [abas_pkg::VoltScW-1:0] v_res;
  abas_pkg::result_t         out_q;

  assign offset_cleared_d = offset_cleared_q
                          || (s2_m1_q < current_zero_q)
                          || (s2_m2_q < current_zero_q);
  assign zero_eff = offset_cleared_d ? '0 : current_zero_q;
  // the offset is dropped whenever a mean sits below it, so these never wrap
  assign c1_diff  = s2_m1_q - zero_eff;
  assign c2_diff  = s2_m2_q - zero_eff;
  assign c1_scl   = CurProdW'(c1_diff) * CurProdW'(current_gain_q);
  assign c2_scl   = CurProdW'(c2_diff) * CurProdW'(current_gain_q);

  assign v_diff = $signed({2'b00, s2_mv_q})
                + VDiffW'($signed(voltage_offset_q));
  assign v_scl  = VProdW'(v_diff[VDiffW-2:0]) * VProdW'(voltage_gain_q);
  // clamp at zero; the floored products stay inside the output ranges
  assign v_res  = (v_diff > 0) ? v_scl[Frac +: abas_pkg::VoltScW] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q      <= 1'b0;
      offset_cleared_q <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
      if (out_adv && s2_valid_q) begin
        offset_cleared_q <= offset_cleared_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s2_valid_q) begin
      out_q.current1_mean   <= s2_m1_q;
      out_q.current2_mean   <= s2_m2_q;
      out_q.voltage_mean    <= s2_mv_q;
      out_q.current1_scaled <= abas_pkg::CurScW'(c1_scl[CurProdW-1:Frac]);
      out_q.current2_scaled <= abas_pkg::CurScW'(c2_scl[CurProdW-1:Frac]);
      out_q.voltage_scaled  <= v_res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------- assertions ----------------
  a_offset_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_cleared_q |=> offset_cleared_q)
    else $error("offset cleared flag dropped");

  a_no_block_lost : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_last |-> s1_free)
    else $error("block sums taken while sum register is full");

  a_block_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_last |=> s1_valid_q)
    else $error("block sums not captured");

  a_means_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_adv |=> s2_valid_q && $stable(s2_m1_q) && $stable(s2_mv_q))
    else $error("means overwritten while output stalled");

endmodule
